FILE: src/hgs_pkg.sv
package hgs_pkg;

    // Site store geometry
    localparam int SITE_W    = 10;
    localparam int NUM_SITES = 1 << SITE_W;
    localparam int CNT_W     = 16;

    // Probability table geometry
    localparam int PROB_AW   = 10;
    localparam int PROB_W    = 17;
    localparam int PROB_SIZE = 1 << PROB_AW;

    // Shared multiplier geometry
    localparam int MUL_W     = 18;
    localparam int PROD_W    = 2 * MUL_W;

    // Item operation codes
    localparam logic [2:0] MODE_ADD         = 3'd0;
    localparam logic [2:0] MODE_REMOVE      = 3'd1;
    localparam logic [2:0] MODE_FLIP        = 3'd2;
    localparam logic [2:0] MODE_SAMPLE_REF  = 3'd3;
    localparam logic [2:0] MODE_SAMPLE_PLAIN = 3'd4;
    localparam logic [2:0] MODE_QUERY       = 3'd5;

    // Read gate codes
    localparam logic [1:0] RM_UNFLIPPED = 2'd0;
    localparam logic [1:0] RM_FLIPPED   = 2'd1;
    localparam logic [1:0] RM_ALL       = 2'd2;
    localparam logic [1:0] RM_RSVD      = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_READ_MODE  = 3'd0;
    localparam logic [2:0] CFG_SMOOTH_MU  = 3'd1;
    localparam logic [2:0] CFG_SEQ_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_SEQ_ERROR  = 3'd3;
    localparam logic [2:0] CFG_EMIT_RIGHT = 3'd4;
    localparam logic [2:0] CFG_EMIT_ERROR = 3'd5;

    // One site entry of the count store
    typedef struct packed {
        logic             hap;
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] c0;
    } site_entry_t;

    // Write port of the count store
    typedef struct packed {
        logic              en;
        logic [SITE_W-1:0] addr;
        site_entry_t       data;
    } mem_wr_t;

    typedef logic [PROB_W-1:0] prob_tab_t [PROB_SIZE];

    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

    // Unsigned 64-bit quotient by restoring long division
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Build round(65536*sigmoid(k/32)) for k in [-512,511], exact integer math
    function automatic prob_tab_t build_prob_tab();
        logic [63:0]  term;
        logic [63:0]  a;
        logic [63:0]  p;
        logic [127:0] wide;
        logic [64:0]  r;
        logic [64:0]  d;
        logic [17:0]  quo;
        logic [17:0]  e;
        prob_tab_t    tab;
        term = ONE_Q62;
        a    = ONE_Q62;
        p    = ONE_Q62;
        // exp(-1/32) as a truncated series
        for (int n = 1; n <= 16; n++) begin
            term = div_u64(term >> 5, 64'(n));
            if ((n & 1) == 1) begin
                a = a - term;
            end
            else begin
                a = a + term;
            end
        end
        for (int k = 0; k <= 512; k++) begin
            d   = {1'b0, ONE_Q62} + {1'b0, p};
            r   = {1'b0, ONE_Q62};
            quo = '0;
            for (int i = 0; i < 17; i++) begin
                r   = r << 1;
                quo = quo << 1;
                if (r >= d) begin
                    r      = r - d;
                    quo[0] = 1'b1;
                end
            end
            e = (quo + 18'd1) >> 1;
            if (k <= 511) begin
                tab[512 + k] = e[PROB_W-1:0];
            end
            if (k >= 1) begin
                tab[512 - k] = PROB_W'(18'd65536 - e);
            end
            wide = p * a;
            p    = wide[125:62];
        end
        return tab;
    endfunction

endpackage

FILE: src/hgs_site_mem.sv
module hgs_site_mem
    import hgs_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic              rd_en,
    input  logic [SITE_W-1:0] rd_addr,
    output site_entry_t       rd_data
);

    site_entry_t mem [NUM_SITES];
    site_entry_t rd_data_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/hgs_prob_rom.sv
module hgs_prob_rom
    import hgs_pkg::*;
(
    input  logic               clk,
    input  logic [PROB_AW-1:0] addr,
    output logic [PROB_W-1:0]  data
);

    localparam prob_tab_t PROB_TAB = build_prob_tab();

    logic [PROB_W-1:0] data_reg;

    // Registered table lookup
    always_ff @(posedge clk)
    begin
        data_reg <= PROB_TAB[addr];
    end

    assign data = data_reg;

endmodule

FILE: src/hgs_mul_unit.sv
module hgs_mul_unit
    import hgs_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Multiply and register the product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: src/haplotype_gibbs_site_sampler_top.sv
// Per-site Gibbs sampler for one binary haplotype. After reset the block runs a
// clearing pass over its 1024-entry count store (in_stall high, configuration
// writes still taken). Add, remove, flip and query items then pass through
// accept, store read and result; sample items insert between store read and
// result three uses of the single 18x18 multiplier by the sequencer, followed
// by the probability table read and the draw. One item is in flight at a
// time; a finished result waits in the output register while the next item is
// taken. Configuration writes belong only to idle periods.
module haplotype_gibbs_site_sampler_top
    import hgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        mode,
    input  logic [SITE_W-1:0] site_index,
    input  logic              allele_bit,
    input  logic              read_flip,
    input  logic              ref_bit,
    input  logic [15:0]       random_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic              bad_mode,
    output logic              hap_bit,
    output logic [CNT_W-1:0]  count_zero,
    output logic [CNT_W-1:0]  count_one
);

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_READ   = 11'b000_0000_0100,
        ST_MUL_DC = 11'b000_0000_1000,
        ST_SUM    = 11'b000_0001_0000,
        ST_MUL_LO = 11'b000_0010_0000,
        ST_MUL_HI = 11'b000_0100_0000,
        ST_ACC    = 11'b000_1000_0000,
        ST_LOOKUP = 11'b001_0000_0000,
        ST_DRAW   = 11'b010_0000_0000,
        ST_POST   = 11'b100_0000_0000
    } state_t;

    localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(NUM_SITES - 1);

    state_t state_reg, state_next;
    logic [SITE_W-1:0] clr_cnt_reg;

    // Configuration registers
    logic [1:0]  read_mode_reg;
    logic [15:0] smooth_mu_reg;
    logic [15:0] seq_right_reg;
    logic [15:0] seq_error_reg;
    logic [15:0] emit_right_reg;
    logic [15:0] emit_error_reg;

    // Item registers
    logic [2:0]        mode_reg;
    logic [SITE_W-1:0] site_reg;
    logic              allele_reg;
    logic              flip_reg;
    logic              ref_reg;
    logic [15:0]       rnd_reg;

    // Working and result registers
    site_entry_t         entry_reg;
    logic                res_acc_reg;
    logic                res_bad_reg;
    logic signed [34:0]  sum_reg;
    logic signed [51:0]  raw_reg;

    // Output registers
    logic              out_valid_reg;
    logic              acc_out_reg;
    logic              bad_out_reg;
    site_entry_t       entry_out_reg;

    logic              in_take;
    logic              out_free;
    mem_wr_t           mem_wr;
    site_entry_t       rd_data;
    site_entry_t       upd_entry;
    logic              upd_acc;
    logic              upd_bad;
    logic              upd_write;
    logic              inc_en;
    logic              inc_sel;
    logic              dec_en;
    logic              dec_sel;
    logic              mul_en;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [16:0] dre;
    logic signed [16:0] dem;
    logic signed [16:0] dc;
    logic signed [16:0] dem_s;
    logic signed [36:0] idx_wide;
    logic [PROB_AW-1:0] rom_addr;
    logic [PROB_W-1:0]  prob;
    logic               new_hap;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_mode_reg  <= RM_UNFLIPPED;
            smooth_mu_reg  <= 16'd4096;
            seq_right_reg  <= 16'd0;
            seq_error_reg  <= 16'hFB65;
            emit_right_reg <= 16'd0;
            emit_error_reg <= 16'hFB65;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_READ_MODE:  read_mode_reg  <= cfg_data[1:0];
                CFG_SMOOTH_MU:  smooth_mu_reg  <= cfg_data;
                CFG_SEQ_RIGHT:  seq_right_reg  <= cfg_data;
                CFG_SEQ_ERROR:  seq_error_reg  <= cfg_data;
                CFG_EMIT_RIGHT: emit_right_reg <= cfg_data;
                CFG_EMIT_ERROR: emit_error_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Element update from the fetched entry
    always_comb
    begin
        upd_acc = 1'b0;
        upd_bad = 1'b0;
        inc_en  = 1'b0;
        inc_sel = 1'b0;
        dec_en  = 1'b0;
        dec_sel = 1'b0;
        case (mode_reg)
            MODE_ADD:
            begin
                if (read_mode_reg == RM_RSVD)
                begin
                    upd_bad = 1'b1;
                end
                else if (read_mode_reg == RM_ALL)
                begin
                    inc_en  = 1'b1;
                    inc_sel = allele_reg ^ flip_reg;
                    upd_acc = 1'b1;
                end
                else if (flip_reg == read_mode_reg[0])
                begin
                    inc_en  = 1'b1;
                    inc_sel = allele_reg;
                    upd_acc = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (read_mode_reg[1])
                begin
                    upd_bad = 1'b1;
                end
                else if (flip_reg != read_mode_reg[0])
                begin
                    dec_en  = 1'b1;
                    dec_sel = allele_reg;
                    upd_acc = 1'b1;
                end
            end
            MODE_FLIP:
            begin
                if (read_mode_reg == RM_ALL)
                begin
                    dec_en  = 1'b1;
                    dec_sel = allele_reg ^ ~flip_reg;
                    inc_en  = 1'b1;
                    inc_sel = allele_reg ^ flip_reg;
                    upd_acc = 1'b1;
                end
            end
            MODE_SAMPLE_REF, MODE_SAMPLE_PLAIN, MODE_QUERY:
            begin
                upd_acc = 1'b1;
            end
            default:
            begin
                upd_bad = 1'b1;
            end
        endcase
        upd_entry = rd_data;
        if (inc_en)
        begin
            if (inc_sel)
            begin
                upd_entry.c1 = sat_inc(rd_data.c1);
            end
            else
            begin
                upd_entry.c0 = sat_inc(rd_data.c0);
            end
        end
        if (dec_en)
        begin
            if (dec_sel)
            begin
                upd_entry.c1 = sat_dec(rd_data.c1);
            end
            else
            begin
                upd_entry.c0 = sat_dec(rd_data.c0);
            end
        end
        upd_write = inc_en || dec_en;
    end

    // Sample operands
    assign dre = 17'(signed'(seq_right_reg)) - 17'(signed'(seq_error_reg));
    assign dem = 17'(signed'(emit_right_reg)) - 17'(signed'(emit_error_reg));
    assign dc  = signed'({1'b0, entry_reg.c0}) - signed'({1'b0, entry_reg.c1});

    always_comb
    begin
        case (mode_reg)
            MODE_SAMPLE_REF: dem_s = ref_reg ? -dem : dem;
            default:         dem_s = '0;
        endcase
    end

    // Drive the shared multiplier
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_DC:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(dre);
                mul_b  = MUL_W'(dc);
            end
            ST_MUL_LO:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({2'b00, smooth_mu_reg});
                mul_b  = signed'({1'b0, sum_reg[16:0]});
            end
            ST_MUL_HI:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({2'b00, smooth_mu_reg});
                mul_b  = sum_reg[34:17];
            end
            default: ;
        endcase
    end

    hgs_mul_unit u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Floor to 1/32, saturate to the table range
    assign idx_wide = raw_reg[51:15];

    always_comb
    begin
        if (idx_wide < -37'sd512)
        begin
            rom_addr = '0;
        end
        else if (idx_wide > 37'sd511)
        begin
            rom_addr = '1;
        end
        else
        begin
            rom_addr = idx_wide[PROB_AW-1:0] ^ {1'b1, {(PROB_AW-1){1'b0}}};
        end
    end

    hgs_prob_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (prob)
    );

    assign new_hap = ({1'b0, rnd_reg} < prob) ? 1'b0 : 1'b1;

    // Store write port
    always_comb
    begin
        mem_wr = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = clr_cnt_reg;
            end
            ST_READ:
            begin
                mem_wr.en   = upd_write;
                mem_wr.addr = site_reg;
                mem_wr.data = upd_entry;
            end
            ST_DRAW:
            begin
                mem_wr.en       = 1'b1;
                mem_wr.addr     = site_reg;
                mem_wr.data     = entry_reg;
                mem_wr.data.hap = new_hap;
            end
            default: ;
        endcase
    end

    hgs_site_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (in_take),
        .rd_addr (site_index),
        .rd_data (rd_data)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == LAST_SITE) state_next = ST_IDLE;
            ST_IDLE:   if (in_take) state_next = ST_READ;
            ST_READ:
            begin
                if (mode_reg == MODE_SAMPLE_REF || mode_reg == MODE_SAMPLE_PLAIN)
                begin
                    state_next = ST_MUL_DC;
                end
                else
                begin
                    state_next = ST_POST;
                end
            end
            ST_MUL_DC: state_next = ST_SUM;
            ST_SUM:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_DRAW;
            ST_DRAW:   state_next = ST_POST;
            ST_POST:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_POST && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg   <= mode;
            site_reg   <= site_index;
            allele_reg <= allele_bit;
            flip_reg   <= read_flip;
            ref_reg    <= ref_bit;
            rnd_reg    <= random_value;
        end
        case (state_reg)
            ST_READ:
            begin
                entry_reg   <= upd_entry;
                res_acc_reg <= upd_acc;
                res_bad_reg <= upd_bad;
            end
            ST_SUM:
            begin
                sum_reg <= 35'(signed'(prod[33:0])) + 35'(dem_s);
            end
            ST_MUL_HI:
            begin
                raw_reg <= 52'(prod);
            end
            ST_ACC:
            begin
                raw_reg <= raw_reg + (52'(prod) <<< 17);
            end
            ST_DRAW:
            begin
                entry_reg.hap <= new_hap;
            end
            default: ;
        endcase
        if (state_reg == ST_POST && out_free)
        begin
            acc_out_reg   <= res_acc_reg;
            bad_out_reg   <= res_bad_reg;
            entry_out_reg <= entry_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = acc_out_reg;
    assign bad_mode   = bad_out_reg;
    assign hap_bit    = entry_out_reg.hap;
    assign count_zero = entry_out_reg.c0;
    assign count_one  = entry_out_reg.c1;

    // Sequencer checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_take_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == ST_READ)
        else $error("accepted item did not start a store read");

    a_draw_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW |->
            (mode_reg == MODE_SAMPLE_REF || mode_reg == MODE_SAMPLE_PLAIN))
        else $error("draw reached by a non-sample item");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> in_stall && mem_wr.en)
        else $error("clearing pass did not hold off input");

    a_post_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST && out_free) |=> out_valid_reg)
        else $error("finished transaction not presented");

endmodule
